// ===== rtl/mrs_pkg.sv =====
package mrs_pkg;

  localparam logic [1:0] OP_BYTE   = 2'd0;
  localparam logic [1:0] OP_GAP    = 2'd1;
  localparam logic [1:0] OP_LOCAL  = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [7:0]  FN_READ      = 8'h03;
  localparam logic [7:0]  FN_WRITE     = 8'h06;
  localparam logic [15:0] CMD_REGISTER = 16'd19;
  localparam int unsigned MIN_FRAME    = 8;
  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [15:0] CRC_POLY     = 16'hA001;
  localparam logic [7:0]  SLAVE_RESET  = 8'd1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_DAT,
    ST_DECIDE,
    ST_R_ADDR,
    ST_R_FUNC,
    ST_R_COUNT,
    ST_R_NEXT,
    ST_R_WHI,
    ST_R_WLO,
    ST_R_CRCLO,
    ST_R_CRCHI,
    ST_ECHO_RD,
    ST_ECHO_EM
  } state_e;

  typedef enum logic [2:0] {
    ES_ADDR,
    ES_FUNC,
    ES_COUNT,
    ES_WHI,
    ES_WLO,
    ES_CRCLO,
    ES_CRCHI,
    ES_ECHO
  } emit_sel_e;

  typedef struct packed {
    logic      accept_byte;
    logic      accept_local;
    logic      close;
    logic      rd_issue;
    logic      scan_byte;
    logic      resp_init;
    logic      cmd_write;
    logic      emit;
    emit_sel_e sel;
  } cmd_t;

  typedef struct packed {
    logic len_ok;
    logic at_last;
    logic frame_ok;
    logic read_ok;
    logic write_ok;
    logic words_done;
    logic out_free;
  } status_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/mrs_ctrl.sv =====
module mrs_ctrl
  import mrs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] op_i,
  input  status_t    st_i,
  output logic       in_ready_o,
  output cmd_t       cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.sel  = ES_ADDR;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          unique case (op_i)
            OP_BYTE:  cmd_o.accept_byte = 1'b1;
            OP_LOCAL: cmd_o.accept_local = 1'b1;
            OP_GAP: begin
              cmd_o.close = 1'b1;
              if (st_i.len_ok) begin
                state_d = ST_SCAN_RD;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SCAN_RD: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = ST_SCAN_DAT;
      end
      ST_SCAN_DAT: begin
        cmd_o.scan_byte = 1'b1;
        state_d         = st_i.at_last ? ST_DECIDE : ST_SCAN_RD;
      end
      ST_DECIDE: begin
        cmd_o.resp_init = 1'b1;
        if (st_i.frame_ok && st_i.read_ok) begin
          state_d = ST_R_ADDR;
        end else if (st_i.frame_ok && st_i.write_ok) begin
          cmd_o.cmd_write = 1'b1;
          state_d         = ST_ECHO_RD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_R_ADDR: begin
        cmd_o.sel = ES_ADDR;
        if (st_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_R_FUNC;
        end
      end
      ST_R_FUNC: begin
        cmd_o.sel = ES_FUNC;
        if (st_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_R_COUNT;
        end
      end
      ST_R_COUNT: begin
        cmd_o.sel = ES_COUNT;
        if (st_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_R_NEXT;
        end
      end
      ST_R_NEXT: begin
        state_d = st_i.words_done ? ST_R_CRCLO : ST_R_WHI;
      end
      ST_R_WHI: begin
        cmd_o.sel = ES_WHI;
        if (st_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_R_WLO;
        end
      end
      ST_R_WLO: begin
        cmd_o.sel = ES_WLO;
        if (st_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_R_NEXT;
        end
      end
      ST_R_CRCLO: begin
        cmd_o.sel = ES_CRCLO;
        if (st_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_R_CRCHI;
        end
      end
      ST_R_CRCHI: begin
        cmd_o.sel = ES_CRCHI;
        if (st_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      ST_ECHO_RD: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = ST_ECHO_EM;
      end
      ST_ECHO_EM: begin
        cmd_o.sel = ES_ECHO;
        if (st_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = st_i.at_last ? ST_IDLE : ST_ECHO_RD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/mrs_dp.sv =====
module mrs_dp
  import mrs_pkg::*;
#(
  parameter int unsigned FRAME_BYTES = 64,
  parameter int unsigned TABLE_WORDS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output status_t     st_o,
  input  logic [7:0]  rx_byte_i,
  input  logic [4:0]  reg_index_i,
  input  logic [15:0] reg_value_i,
  input  logic        cfg_valid_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output logic [7:0]  tx_byte_o,
  output logic        tx_last_o,
  output logic [3:0]  pin_drive_o
);

  localparam int unsigned AW = $clog2(FRAME_BYTES);
  localparam int unsigned LW = $clog2(FRAME_BYTES + 1);
  localparam int unsigned IW = $clog2(TABLE_WORDS);
  localparam int unsigned KW = $clog2(TABLE_WORDS + 1);

  logic [7:0]  mem [FRAME_BYTES];
  logic [7:0]  rdata_q;
  logic [LW-1:0] len_q, flen_q, idx_q;
  logic        ovf_q;
  logic [15:0] tbl_q [TABLE_WORDS];
  logic [3:0]  pin_q;
  logic [7:0]  slave_q;
  logic [15:0] crc_q;
  logic [7:0]  sa_q, fn_q, lo_q, hi_q;
  logic [15:0] addr_q, val_q;
  logic [KW-1:0] k_q;
  logic        out_valid_q, tx_last_q;
  logic [7:0]  tx_byte_q;
  logic [3:0]  pin_out_q;

  logic [IW-1:0] word_idx;
  logic [15:0]   word;
  logic [7:0]    emit_byte;
  logic          emit_last;
  logic [16:0]   range_end;

  assign word_idx  = addr_q[IW-1:0] + IW'(k_q);
  assign word      = tbl_q[word_idx];
  assign range_end = {1'b0, addr_q} + {1'b0, val_q};

  always_comb begin
    emit_last = 1'b0;
    unique case (cmd_i.sel)
      ES_ADDR:  emit_byte = slave_q;
      ES_FUNC:  emit_byte = FN_READ;
      ES_COUNT: emit_byte = {val_q[6:0], 1'b0};
      ES_WHI:   emit_byte = word[15:8];
      ES_WLO:   emit_byte = word[7:0];
      ES_CRCLO: emit_byte = crc_q[7:0];
      ES_CRCHI: begin
        emit_byte = crc_q[15:8];
        emit_last = 1'b1;
      end
      ES_ECHO: begin
        emit_byte = rdata_q;
        emit_last = st_o.at_last;
      end
      default:  emit_byte = 8'h00;
    endcase
  end

  always_comb begin
    st_o.len_ok     = !ovf_q && (len_q >= LW'(MIN_FRAME));
    st_o.at_last    = (idx_q == flen_q - LW'(1));
    st_o.frame_ok   = (sa_q == slave_q) && (crc_q == {hi_q, lo_q});
    st_o.read_ok    = (fn_q == FN_READ) && (range_end <= 17'(TABLE_WORDS));
    st_o.write_ok   = (fn_q == FN_WRITE) && (addr_q == CMD_REGISTER);
    st_o.words_done = ({{(16 - KW){1'b0}}, k_q} == val_q);
    st_o.out_free   = !out_valid_q || out_ready_i;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept_byte && (len_q < LW'(FRAME_BYTES))) begin
      mem[len_q[AW-1:0]] <= rx_byte_i;
    end
    if (cmd_i.rd_issue) begin
      rdata_q <= mem[idx_q[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.close) begin
      flen_q <= len_q;
    end
    if (cmd_i.scan_byte) begin
      if (idx_q < flen_q - LW'(2)) begin
        crc_q <= crc_byte(crc_q, rdata_q);
      end
      lo_q <= hi_q;
      hi_q <= rdata_q;
      unique case (idx_q)
        LW'(0):  sa_q <= rdata_q;
        LW'(1):  fn_q <= rdata_q;
        LW'(2):  addr_q[15:8] <= rdata_q;
        LW'(3):  addr_q[7:0] <= rdata_q;
        LW'(4):  val_q[15:8] <= rdata_q;
        LW'(5):  val_q[7:0] <= rdata_q;
        default: ;
      endcase
    end else if (cmd_i.resp_init || cmd_i.close) begin
      crc_q <= CRC_INIT;
    end else if (cmd_i.emit && (cmd_i.sel != ES_CRCLO) && (cmd_i.sel != ES_CRCHI)
                 && (cmd_i.sel != ES_ECHO)) begin
      crc_q <= crc_byte(crc_q, emit_byte);
    end
    if (cmd_i.emit) begin
      tx_byte_q <= emit_byte;
      tx_last_q <= emit_last;
      pin_out_q <= pin_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      ovf_q       <= 1'b0;
      idx_q       <= '0;
      k_q         <= '0;
      pin_q       <= '0;
      slave_q     <= SLAVE_RESET;
      out_valid_q <= 1'b0;
      for (int i = 0; i < TABLE_WORDS; i++) begin
        tbl_q[i] <= '0;
      end
    end else begin
      if (cfg_valid_i) begin
        slave_q <= cfg_data_i;
      end
      if (cmd_i.accept_byte) begin
        if (len_q < LW'(FRAME_BYTES)) begin
          len_q <= len_q + LW'(1);
        end else begin
          ovf_q <= 1'b1;
        end
      end
      if (cmd_i.close) begin
        len_q <= '0;
        ovf_q <= 1'b0;
        idx_q <= '0;
      end
      if (cmd_i.accept_local && ({1'b0, reg_index_i} < 6'(TABLE_WORDS))) begin
        tbl_q[reg_index_i[IW-1:0]] <= reg_value_i;
      end
      if (cmd_i.scan_byte) begin
        idx_q <= idx_q + LW'(1);
      end
      if (cmd_i.resp_init) begin
        idx_q <= '0;
        k_q   <= '0;
      end
      if (cmd_i.cmd_write) begin
        tbl_q[CMD_REGISTER[IW-1:0]] <= val_q;
        pin_q <= val_q[3:0];
      end
      if (cmd_i.emit && (cmd_i.sel == ES_WLO)) begin
        k_q <= k_q + KW'(1);
      end
      if (cmd_i.emit && (cmd_i.sel == ES_ECHO)) begin
        idx_q <= idx_q + LW'(1);
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign tx_byte_o   = tx_byte_q;
  assign tx_last_o   = tx_last_q;
  assign pin_drive_o = pin_out_q;

endmodule

// ===== rtl/modbus_rtu_register_slave.sv =====
// Channel   Direction  Handshake               Payload
// in        input      in_valid_i/in_ready_o   op_i, rx_byte_i, reg_index_i, reg_value_i
// out       output     out_valid_o/out_ready_i tx_byte_o, tx_last_o, pin_drive_o
// cfg       input      cfg_valid_i/cfg_ready_o cfg_data_i (slave address)
//
// A received byte or a local table write is taken whenever the sequencer is idle.
// An idle gap reads the frame buffer byte by byte and checks the CRC, then sends the
// header bytes, each register word high byte first and the CRC low byte first of a read
// response, or reads and echoes each byte of a write frame, while out_ready_i is high.
// Async reset clears the control state, register table and pin register, not pin_drive_o.
// A stalled output holds the sequencer; a new request is taken only while it is idle.
module modbus_rtu_register_slave
  import mrs_pkg::*;
#(
  parameter int unsigned FRAME_BYTES = 64,
  parameter int unsigned TABLE_WORDS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic [7:0]  rx_byte_i,
  input  logic [4:0]  reg_index_i,
  input  logic [15:0] reg_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  tx_byte_o,
  output logic        tx_last_o,
  output logic [3:0]  pin_drive_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i
);

  cmd_t    cmd;
  status_t st;

  assign cfg_ready_o = 1'b1;

  mrs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .op_i       (op_i),
    .st_i       (st),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  mrs_dp #(
    .FRAME_BYTES (FRAME_BYTES),
    .TABLE_WORDS (TABLE_WORDS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .st_o        (st),
    .rx_byte_i   (rx_byte_i),
    .reg_index_i (reg_index_i),
    .reg_value_i (reg_value_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .tx_byte_o   (tx_byte_o),
    .tx_last_o   (tx_last_o),
    .pin_drive_o (pin_drive_o)
  );

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import mrs_pkg::*;

  localparam int NBUF = 64;
  localparam int NTAB = 24;
  localparam int WATCH_LIMIT = 3000;
  localparam int SETTLE = 300;

  typedef enum int {K_FRAME, K_LOCAL, K_OP3} row_kind_e;

  typedef struct {
    row_kind_e  kind;
    logic [7:0] slave;
    logic [7:0] fn;
    logic [15:0] addr;
    logic [15:0] val;
    int         extra;
    int         bad;
    int         cut;
    int         exp_n;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  op = OP_BYTE;
  logic [7:0]  rx_byte = 8'h00;
  logic [4:0]  reg_index = 5'd0;
  logic [15:0] reg_value = 16'h0000;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  tx_byte;
  logic        tx_last;
  logic [3:0]  pin_drive;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = 8'h00;

  logic [7:0]  m_slave;
  logic [7:0]  m_buf [NBUF];
  int          m_len;
  bit          m_ovf;
  logic [15:0] m_table [NTAB];
  logic [3:0]  m_pins;

  logic [7:0]  resp_byte_q [$];
  logic        resp_last_q [$];
  logic [3:0]  resp_pins_q [$];

  int errors = 0;
  int items = 0;
  int seen = 0;
  int last_n = 0;
  int idle_cycles = 0;
  bit quiet = 1'b0;
  bit held = 1'b0;

  modbus_rtu_register_slave dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .op_i(op), .rx_byte_i(rx_byte), .reg_index_i(reg_index), .reg_value_i(reg_value),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .tx_byte_o(tx_byte), .tx_last_o(tx_last), .pin_drive_o(pin_drive),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_data_i(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report(input string what, input int got, input int want);
    $display("ERROR %0t: %s got %0h expected %0h", $time, what, got, want);
    errors++;
  endtask

  function automatic logic [15:0] modbus_crc(input logic [7:0] data [80], input int count);
    logic [15:0] c;
    c = 16'hFFFF;
    for (int k = 0; k < count; k++) begin
      c ^= {8'h00, data[k]};
      for (int b = 0; b < 8; b++) begin
        c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
      end
    end
    return c;
  endfunction

  task automatic queue_response(input logic [7:0] data [80], input int count);
    for (int k = 0; k < count; k++) begin
      resp_byte_q.push_back(data[k]);
      resp_last_q.push_back(k + 1 == count);
      resp_pins_q.push_back(m_pins);
    end
    last_n = count;
  endtask

  task automatic close_frame();
    logic [7:0]  frame [80];
    logic [7:0]  resp [80];
    logic [15:0] crc;
    logic [15:0] word;
    int len, n;
    int unsigned start, qty;
    bit ovf;
    len = m_len;
    ovf = m_ovf;
    m_len = 0;
    m_ovf = 1'b0;
    last_n = 0;
    if (ovf || len < MIN_FRAME || m_buf[0] != m_slave) return;
    for (int k = 0; k < 80; k++) frame[k] = (k < len) ? m_buf[k] : 8'h00;
    crc = modbus_crc(frame, len - 2);
    if (crc != {frame[len-1], frame[len-2]}) return;
    start = {frame[2], frame[3]};
    qty = {frame[4], frame[5]};
    if (frame[1] == FN_READ) begin
      if (start + qty > NTAB) return;
      resp[0] = m_slave;
      resp[1] = FN_READ;
      resp[2] = 8'(qty * 2);
      n = 3;
      for (int k = 0; k < qty; k++) begin
        word = m_table[start + k];
        resp[n++] = word[15:8];
        resp[n++] = word[7:0];
      end
      crc = modbus_crc(resp, n);
      resp[n++] = crc[7:0];
      resp[n++] = crc[15:8];
      queue_response(resp, n);
    end else if (frame[1] == FN_WRITE && start == CMD_REGISTER) begin
      m_table[CMD_REGISTER] = 16'(qty);
      m_pins = qty[3:0];
      queue_response(frame, len);
    end
  endtask

  task automatic predict(input logic [1:0] o, input logic [7:0] b, input logic [4:0] idx,
                         input logic [15:0] v);
    case (o)
      OP_BYTE: begin
        if (m_len < NBUF) m_buf[m_len++] = b;
        else m_ovf = 1'b1;
      end
      OP_GAP: close_frame();
      OP_LOCAL: begin
        if (idx < NTAB) m_table[idx] = v;
      end
      default: ;
    endcase
  endtask

  task automatic send_item(input logic [1:0] o, input logic [7:0] b, input logic [4:0] idx,
                           input logic [15:0] v);
    int gap;
    bit ok;
    gap = quiet ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= o;
    rx_byte <= b;
    reg_index <= idx;
    reg_value <= v;
    do begin
      @(negedge clk);
      ok = in_ready;
      @(posedge clk);
    end while (!ok);
    predict(o, b, idx, v);
    items++;
  endtask

  task automatic send_frame(input logic [7:0] sl, input logic [7:0] fn, input logic [15:0] a,
                            input logic [15:0] v, input int extra, input int bad,
                            input int cut);
    logic [7:0]  fr [80];
    logic [15:0] crc;
    int n;
    fr[0] = sl;
    fr[1] = fn;
    fr[2] = a[15:8];
    fr[3] = a[7:0];
    fr[4] = v[15:8];
    fr[5] = v[7:0];
    n = 6;
    for (int k = 0; k < extra; k++) fr[n++] = 8'($urandom);
    crc = modbus_crc(fr, n);
    fr[n++] = crc[7:0] ^ (bad ? 8'h5A : 8'h00);
    fr[n++] = crc[15:8];
    if (cut > 0) n = cut;
    for (int k = 0; k < n; k++) send_item(OP_BYTE, fr[k], 5'($urandom), 16'($urandom));
    send_item(OP_GAP, 8'($urandom), 5'($urandom), 16'($urandom));
  endtask

  task automatic write_slave(input logic [7:0] value);
    bit ok;
    in_valid <= 1'b0;
    while (resp_byte_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do begin
      @(negedge clk);
      ok = cfg_ready;
      @(posedge clk);
    end while (!ok);
    cfg_valid <= 1'b0;
    m_slave = value;
  endtask

  task automatic random_request();
    int r, a, q, hi;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      a = $urandom_range(0, NTAB - 1);
      hi = ($urandom_range(0, 3) == 0) ? NTAB - a : ((NTAB - a < 4) ? NTAB - a : 4);
      q = $urandom_range(0, hi);
      send_frame(m_slave, FN_READ, 16'(a), 16'(q), ($urandom_range(0, 4) == 0) ? 2 : 0, 0, 0);
    end else if (r < 55) begin
      send_frame(m_slave, FN_WRITE, CMD_REGISTER, 16'($urandom),
                 $urandom_range(0, 1) ? 0 : $urandom_range(1, 6), 0, 0);
    end else if (r < 63) begin
      send_item(OP_LOCAL, 8'($urandom), 5'($urandom_range(0, 31)), 16'($urandom));
    end else if (r < 68) begin
      send_frame(m_slave, FN_READ, 16'd0, 16'd2, 0, 1, 0);
    end else if (r < 72) begin
      send_frame(m_slave ^ 8'($urandom_range(1, 255)), FN_WRITE, CMD_REGISTER,
                 16'($urandom), 0, 0, 0);
    end else if (r < 76) begin
      send_frame(m_slave, 8'($urandom), 16'($urandom), 16'($urandom), 0, 0, 0);
    end else if (r < 80) begin
      a = $urandom_range(1, NTAB);
      send_frame(m_slave, FN_READ, 16'(a), 16'(NTAB - a + 1), 0, 0, 0);
    end else if (r < 84) begin
      send_frame(m_slave, FN_WRITE, 16'($urandom_range(0, 18)), 16'($urandom), 0, 0, 0);
    end else if (r < 88) begin
      send_frame(m_slave, FN_READ, 16'd0, 16'd1, 0, 0, $urandom_range(1, 7));
    end else if (r < 91) begin
      send_frame(m_slave, FN_WRITE, CMD_REGISTER, 16'($urandom), 60, 0, 0);
    end else if (r < 94) begin
      send_item(OP_UNUSED, 8'($urandom), 5'($urandom), 16'($urandom));
    end else if (r < 97) begin
      repeat ($urandom_range(1, 10)) send_item(OP_BYTE, 8'($urandom), 5'd0, 16'd0);
      send_item(OP_GAP, 8'd0, 5'd0, 16'd0);
    end else begin
      send_item(OP_GAP, 8'($urandom), 5'($urandom), 16'($urandom));
    end
  endtask

  row_t rows [21] = '{
    '{K_FRAME, 8'd1, FN_READ, 16'd0, 16'd1, 0, 0, 0, 7},
    '{K_FRAME, 8'd1, FN_READ, 16'd0, 16'd0, 0, 0, 0, 5},
    '{K_LOCAL, 8'd0, 8'd0, 16'd0, 16'hFFFF, 0, 0, 0, 0},
    '{K_LOCAL, 8'd0, 8'd0, 16'd23, 16'hA5C3, 0, 0, 0, 0},
    '{K_LOCAL, 8'd0, 8'd0, 16'd31, 16'h1234, 0, 0, 0, 0},
    '{K_LOCAL, 8'd0, 8'd0, 16'd19, 16'h000F, 0, 0, 0, 0},
    '{K_FRAME, 8'd1, FN_READ, 16'd0, 16'd24, 0, 0, 0, 53},
    '{K_FRAME, 8'd1, FN_READ, 16'd1, 16'd24, 0, 0, 0, 0},
    '{K_FRAME, 8'd1, FN_READ, 16'hFFFF, 16'hFFFF, 0, 0, 0, 0},
    '{K_FRAME, 8'd1, FN_WRITE, 16'd19, 16'h0005, 0, 0, 0, 8},
    '{K_FRAME, 8'd1, FN_WRITE, 16'd19, 16'hFFFA, 56, 0, 0, 64},
    '{K_FRAME, 8'd1, FN_WRITE, 16'd18, 16'h0003, 0, 0, 0, 0},
    '{K_FRAME, 8'd1, 8'h10, 16'd0, 16'd1, 0, 0, 0, 0},
    '{K_FRAME, 8'd2, FN_READ, 16'd0, 16'd1, 0, 0, 0, 0},
    '{K_FRAME, 8'd1, FN_READ, 16'd0, 16'd1, 0, 1, 0, 0},
    '{K_FRAME, 8'd1, FN_READ, 16'd0, 16'd1, 0, 0, 7, 0},
    '{K_FRAME, 8'd1, FN_WRITE, 16'd19, 16'h0001, 58, 0, 0, 0},
    '{K_OP3, 8'd0, 8'd0, 16'd0, 16'd0, 0, 0, 0, 0},
    '{K_FRAME, 8'd1, FN_READ, 16'd20, 16'd4, 2, 0, 0, -1},
    '{K_FRAME, 8'd1, FN_WRITE, 16'd19, 16'h0000, 0, 0, 0, 8},
    '{K_FRAME, 8'd1, FN_READ, 16'd19, 16'd1, 0, 0, 0, 7}
  };

  initial begin
    bit ok;
    logic [7:0] got_b;
    logic got_l;
    logic [3:0] got_p;
    int gap;
    forever begin
      gap = quiet ? 0 : $urandom_range(0, 3);
      if (seen == 40 && !held) begin
        held = 1'b1;
        gap = 600;
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do begin
        @(negedge clk);
        ok = out_valid;
        got_b = tx_byte;
        got_l = tx_last;
        got_p = pin_drive;
        @(posedge clk);
      end while (!ok);
      seen++;
      if (resp_byte_q.size() == 0) begin
        report("unexpected tx_byte", got_b, 0);
      end else begin
        if (got_b != resp_byte_q[0]) report("tx_byte", got_b, resp_byte_q[0]);
        if (got_l != resp_last_q[0]) report("tx_last", got_l, resp_last_q[0]);
        if (got_p != resp_pins_q[0]) report("pin_drive", got_p, resp_pins_q[0]);
        void'(resp_byte_q.pop_front());
        void'(resp_last_q.pop_front());
        void'(resp_pins_q.pop_front());
      end
    end
  end

  always @(negedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (rst_n) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCH_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    int base;
    m_slave = SLAVE_RESET;
    m_len = 0;
    m_ovf = 1'b0;
    m_pins = 4'h0;
    for (int k = 0; k < NTAB; k++) m_table[k] = 16'h0000;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (rows[i]) begin
      last_n = 0;
      case (rows[i].kind)
        K_FRAME: send_frame(rows[i].slave, rows[i].fn, rows[i].addr, rows[i].val,
                            rows[i].extra, rows[i].bad, rows[i].cut);
        K_LOCAL: send_item(OP_LOCAL, 8'h00, rows[i].addr[4:0], rows[i].val);
        default: send_item(OP_UNUSED, 8'hFF, 5'h1F, 16'hFFFF);
      endcase
      if (rows[i].exp_n >= 0 && last_n != rows[i].exp_n)
        report("response length", last_n, rows[i].exp_n);
    end
    base = items;
    write_slave(8'h00);
    while (items < base + 10) begin
      quiet = ($urandom_range(0, 3) == 0);
      random_request();
    end
    write_slave(8'hFF);
    while (items < base + 20) begin
      quiet = ($urandom_range(0, 3) == 0);
      random_request();
    end
    write_slave(8'($urandom));
    while (items < base + 30) begin
      quiet = ($urandom_range(0, 3) == 0);
      random_request();
    end
    in_valid <= 1'b0;
    while (resp_byte_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/mrs_pkg.sv
rtl/mrs_ctrl.sv
rtl/mrs_dp.sv
rtl/modbus_rtu_register_slave.sv
sim/tb.sv
